// ===== rtl/core/cjd_pkg.sv =====
// Shared types, constants and lookup tables for the calendar / day number converter.
// No dependencies; every other file of the block refers to this package by scoped names.

package cjd_pkg;

	// Conversion direction carried in the mode field of a request word.
	typedef enum logic {
		MODE_TO_DAY_NUMBER = 1'b0,
		MODE_TO_DATE       = 1'b1
	} mode_t;

	// Request word: both the date and the day number travel, mode picks one.
	typedef struct packed {
		logic        mode;
		logic [11:0] year_in;
		logic [3:0]  month_in;
		logic [4:0]  day_in;
		logic [21:0] day_number_in;
	} req_word_t;

	// Result word: fields that do not belong to the mode are zero.
	typedef struct packed {
		logic [21:0] day_number_out;
		logic [11:0] year_out;
		logic [3:0]  month_out;
		logic [4:0]  day_out;
		logic [8:0]  day_of_year_out;
	} rsp_word_t;

	// Number of pipeline stages, the result register included.
	localparam int unsigned NUM_STAGES = 8;

	// Day number of the epoch that the shifted calendar counts from.
	localparam logic signed [23:0] EPOCH_DAYS = 24'sd1720982;

	// Days per year scaled by 100 (365.25) and its 122.1 offset, also scaled by 100.
	localparam logic signed [29:0] JDU_SCALE  = 30'sd100;
	localparam logic signed [29:0] JDU_OFFSET = 30'sd12210;
	localparam logic [28:0]        YEAR_DAYS_X100 = 29'd36525;

	// Reciprocal of 36525 scaled by 2^28; the estimate is low by at most one.
	localparam logic [40:0] YEAR_RECIP       = 41'd7349;
	localparam int unsigned YEAR_RECIP_SHIFT = 28;

	// Whole days of a year; the quarter day is added as a shift.
	localparam logic signed [23:0] DAYS_PER_YEAR = 24'sd365;

	// Exact reciprocal of 25 for values below 2^13, scaled by 2^18.
	localparam logic [26:0] DIV25_RECIP = 27'd10486;
	localparam int unsigned DIV25_SHIFT = 18;
	localparam logic [13:0] CENTURY_FACTOR = 14'd25;

	// Thresholds tested when the month count is recovered from the day remainder.
	localparam int unsigned MONTH_STEPS = 15;

	// Shifted month codes that stand for January and February.
	localparam logic signed [4:0] SHIFT_JAN = 5'sd14;
	localparam logic signed [4:0] SHIFT_FEB = 5'sd15;
	localparam logic [3:0]        MONTH_JAN = 4'd1;
	localparam logic [3:0]        MONTH_FEB = 4'd2;

	// Truncated 30.6001 times the index.
	function automatic logic [8:0] month_span(input logic [4:0] idx);
		logic [8:0] span;
		unique case (idx)
			5'd0:    span = 9'd0;
			5'd1:    span = 9'd30;
			5'd2:    span = 9'd61;
			5'd3:    span = 9'd91;
			5'd4:    span = 9'd122;
			5'd5:    span = 9'd153;
			5'd6:    span = 9'd183;
			5'd7:    span = 9'd214;
			5'd8:    span = 9'd244;
			5'd9:    span = 9'd275;
			5'd10:   span = 9'd306;
			5'd11:   span = 9'd336;
			5'd12:   span = 9'd367;
			5'd13:   span = 9'd397;
			5'd14:   span = 9'd428;
			5'd15:   span = 9'd459;
			5'd16:   span = 9'd489;
			default: span = 9'd0;
		endcase
		return span;
	endfunction

	// Days in the first n months of a common year.
	function automatic logic [8:0] days_before(input logic [3:0] n);
		logic [8:0] days;
		unique case (n)
			4'd0:    days = 9'd0;
			4'd1:    days = 9'd31;
			4'd2:    days = 9'd59;
			4'd3:    days = 9'd90;
			4'd4:    days = 9'd120;
			4'd5:    days = 9'd151;
			4'd6:    days = 9'd181;
			4'd7:    days = 9'd212;
			4'd8:    days = 9'd243;
			4'd9:    days = 9'd273;
			4'd10:   days = 9'd304;
			4'd11:   days = 9'd334;
			default: days = 9'd365;
		endcase
		return days;
	endfunction

endpackage

// ===== rtl/core/cjd_req_if.sv =====
// Request channel of the converter: valid, ready and one request word.
// Depends on cjd_pkg for the word type.

interface cjd_req_if;
	logic              valid;
	logic              ready;
	cjd_pkg::req_word_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/cjd_rsp_if.sv =====
// Result channel of the converter: valid, ready and one result word.
// Depends on cjd_pkg for the word type.

interface cjd_rsp_if;
	logic              valid;
	logic              ready;
	cjd_pkg::rsp_word_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/calendar_julian_day_converter.sv =====
// Calendar date / Julian day number converter, eight-stage pipeline.
// Depends on cjd_pkg, cjd_req_if and cjd_rsp_if.
//
// Usage:
// The request channel takes one word per handshake (valid and ready high at a
// rising edge of clk). Mode 0 turns year, month and day into a day number; mode 1
// turns a day number into year, month, day and day of year. The result channel
// gives one word for every request word, in order; fields that do not belong to
// the mode are zero.
// The request word passes through the eight register stages, the last of which is
// the result register. One word is accepted in every cycle as long as the result
// channel takes its words; a new request enters before the last one is through.
// Each stage holds its own valid bit, so when the receiver stalls the result
// register holds its word and empty stages further back keep filling; the request
// channel drops ready only once every stage is full. Nothing is lost or repeated.
// Asynchronous reset (arst_n low) empties the pipeline; no result is valid after
// reset until a request has passed through.

module calendar_julian_day_converter (
	input logic            clk,
	input logic            arst_n,
	cjd_req_if.sink        request,
	cjd_rsp_if.source      result
);

	// Stage valid bits and per-stage load enables.
	logic [cjd_pkg::NUM_STAGES-1:0] vld_q;
	logic [cjd_pkg::NUM_STAGES-1:0] adv;
	logic [cjd_pkg::NUM_STAGES-1:0] vld_in;

	// Stage 1: mode 0 result and scaled day count for mode 1.
	logic              is_jf;
	logic signed [12:0] yp;
	logic [4:0]        mp;
	logic signed [23:0] ap;
	logic signed [23:0] quarter;
	logic signed [23:0] jn_sum;
	logic signed [23:0] jdu;
	logic signed [29:0] nval;
	logic [27:0]       nabs;

	logic              mode_s1;
	logic [21:0]       jn_s1;
	logic signed [23:0] jdu_s1;
	logic              nneg_s1;
	logic [27:0]       nabs_s1;

	// Stage 2: year estimate from the reciprocal.
	logic [40:0]       yprod;
	logic              mode_s2;
	logic [21:0]       jn_s2;
	logic signed [23:0] jdu_s2;
	logic              nneg_s2;
	logic [27:0]       nabs_s2;
	logic [12:0]       q0_s2;

	// Stage 3: corrected year magnitude.
	logic [28:0]       yrem;
	logic [12:0]       qfix;
	logic              mode_s3;
	logic [21:0]       jn_s3;
	logic signed [23:0] jdu_s3;
	logic              yneg_s3;
	logic [12:0]       ymag_s3;

	// Stage 4: days left after the whole years.
	logic signed [23:0] amag;
	logic signed [23:0] asig;
	logic signed [23:0] ediff;
	logic              mode_s4;
	logic [21:0]       jn_s4;
	logic signed [9:0] e_s4;
	logic signed [13:0] y1_s4;

	// Stage 5: month count.
	logic [8:0]                        eabs;
	logic [cjd_pkg::MONTH_STEPS-1:0]   thermo;
	logic                              mode_s5;
	logic [21:0]                       jn_s5;
	logic signed [9:0]                 e_s5;
	logic signed [13:0]                y1_s5;
	logic                              m1neg_s5;
	logic [3:0]                        m1mag_s5;

	// Stage 6: day of month, month and year.
	logic [8:0]        bmag;
	logic signed [9:0] bsig;
	logic signed [9:0] dfull;
	logic signed [4:0] m1;
	logic signed [4:0] mo;
	logic signed [13:0] yr;
	logic [3:0]        nmon;
	logic [12:0]       yabs;
	logic              mode_s6;
	logic [21:0]       jn_s6;
	logic [5:0]        dy_s6;
	logic [4:0]        mo_s6;
	logic [13:0]       yr_s6;
	logic [12:0]       yabs_s6;
	logic [3:0]        nmon_s6;

	// Stage 7: quotient by 25 for the century test.
	logic [26:0]       p25;
	logic              mode_s7;
	logic [21:0]       jn_s7;
	logic [5:0]        dy_s7;
	logic [4:0]        mo_s7;
	logic [13:0]       yr_s7;
	logic [12:0]       yabs_s7;
	logic [3:0]        nmon_s7;
	logic [8:0]        q25_s7;

	// Stage 8: leap test, day of year and the result register.
	logic              div25;
	logic              leap;
	logic [9:0]        doy;
	cjd_pkg::rsp_word_t rsp_s8;
	cjd_pkg::rsp_word_t rsp_d;

	// A stage loads when it is empty or the stage after it moves on.
	always_comb begin
		adv[cjd_pkg::NUM_STAGES-1] = ~vld_q[cjd_pkg::NUM_STAGES-1] | result.ready;
		for (int k = cjd_pkg::NUM_STAGES - 2; k >= 0; k--) begin
			adv[k] = ~vld_q[k] | adv[k+1];
		end
	end

	assign vld_in        = {vld_q[cjd_pkg::NUM_STAGES-2:0], request.valid};
	assign request.ready = adv[0];
	assign result.valid  = vld_q[cjd_pkg::NUM_STAGES-1];
	assign result.data   = rsp_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 0; k < cjd_pkg::NUM_STAGES; k++) begin
				if (adv[k]) begin
					vld_q[k] <= vld_in[k];
				end
			end
		end
	end

	// Stage 1 logic: shift January and February into the year before.
	always_comb begin
		is_jf   = (request.data.month_in == cjd_pkg::MONTH_JAN) ||
		          (request.data.month_in == cjd_pkg::MONTH_FEB);
		yp      = $signed({1'b0, request.data.year_in}) - (is_jf ? 13'sd1 : 13'sd0);
		mp      = {1'b0, request.data.month_in} + (is_jf ? 5'd13 : 5'd1);
		ap      = 24'(yp) * cjd_pkg::DAYS_PER_YEAR;
		// The shifted year is never below -1, whose quarter truncates to zero.
		quarter = yp[12] ? 24'sd0 : $signed({13'b0, yp[12:2]});
		jn_sum  = $signed({19'b0, request.data.day_in}) + cjd_pkg::EPOCH_DAYS + ap + quarter +
		          $signed({15'b0, cjd_pkg::month_span(mp)});
		jdu     = $signed({2'b00, request.data.day_number_in}) - cjd_pkg::EPOCH_DAYS;
		nval    = 30'(jdu) * cjd_pkg::JDU_SCALE - cjd_pkg::JDU_OFFSET;
		nabs    = nval[29] ? 28'(-nval) : 28'(nval);
	end

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			mode_s1 <= request.data.mode;
			jn_s1   <= jn_sum[21:0];
			jdu_s1  <= jdu;
			nneg_s1 <= nval[29];
			nabs_s1 <= nabs;
		end
	end

	// Stage 2 logic: year estimate, low by at most one.
	assign yprod = 41'(nabs_s1) * cjd_pkg::YEAR_RECIP;

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			mode_s2 <= mode_s1;
			jn_s2   <= jn_s1;
			jdu_s2  <= jdu_s1;
			nneg_s2 <= nneg_s1;
			nabs_s2 <= nabs_s1;
			q0_s2   <= yprod[cjd_pkg::YEAR_RECIP_SHIFT +: 13];
		end
	end

	// Stage 3 logic: bump the estimate when the remainder still holds a year.
	always_comb begin
		yrem = 29'(nabs_s2) - 29'(q0_s2) * cjd_pkg::YEAR_DAYS_X100;
		qfix = q0_s2 + 13'(yrem >= cjd_pkg::YEAR_DAYS_X100);
	end

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			mode_s3 <= mode_s2;
			jn_s3   <= jn_s2;
			jdu_s3  <= jdu_s2;
			yneg_s3 <= nneg_s2;
			ymag_s3 <= qfix;
		end
	end

	// Stage 4 logic: whole-year days, truncated toward zero, off the day count.
	always_comb begin
		amag  = $signed({11'b0, ymag_s3}) * cjd_pkg::DAYS_PER_YEAR +
		        $signed({13'b0, ymag_s3[12:2]});
		asig  = yneg_s3 ? -amag : amag;
		ediff = jdu_s3 - asig;
	end

	always_ff @(posedge clk) begin
		if (adv[3]) begin
			mode_s4 <= mode_s3;
			jn_s4   <= jn_s3;
			e_s4    <= ediff[9:0];
			y1_s4   <= yneg_s3 ? -$signed({1'b0, ymag_s3}) : $signed({1'b0, ymag_s3});
		end
	end

	// Stage 5 logic: count the month spans that fit into the remaining days.
	always_comb begin
		eabs = e_s4[9] ? 9'(-e_s4) : 9'(e_s4);
		for (int k = 0; k < cjd_pkg::MONTH_STEPS; k++) begin
			thermo[k] = eabs > cjd_pkg::month_span(5'(k + 1));
		end
	end

	always_ff @(posedge clk) begin
		if (adv[4]) begin
			mode_s5  <= mode_s4;
			jn_s5    <= jn_s4;
			e_s5     <= e_s4;
			y1_s5    <= y1_s4;
			m1neg_s5 <= e_s4[9];
			m1mag_s5 <= 4'($countones(thermo));
		end
	end

	// Stage 6 logic: day of month, calendar month and the year it falls in.
	always_comb begin
		bmag  = cjd_pkg::month_span({1'b0, m1mag_s5});
		bsig  = m1neg_s5 ? -$signed({1'b0, bmag}) : $signed({1'b0, bmag});
		dfull = e_s5 - bsig;
		m1    = m1neg_s5 ? -$signed({1'b0, m1mag_s5}) : $signed({1'b0, m1mag_s5});
		mo    = (m1 == cjd_pkg::SHIFT_JAN || m1 == cjd_pkg::SHIFT_FEB) ? m1 - 5'sd13 : m1 - 5'sd1;
		yr    = (mo > 5'sd2) ? y1_s5 : y1_s5 + 14'sd1;
		nmon  = (mo <= 5'sd1) ? 4'd0 : 4'(mo - 5'sd1);
		yabs  = yr[13] ? 13'(-yr) : 13'(yr);
	end

	always_ff @(posedge clk) begin
		if (adv[5]) begin
			mode_s6 <= mode_s5;
			jn_s6   <= jn_s5;
			dy_s6   <= dfull[5:0];
			mo_s6   <= mo;
			yr_s6   <= yr;
			yabs_s6 <= yabs;
			nmon_s6 <= nmon;
		end
	end

	// Stage 7 logic: exact quotient of the year magnitude by 25.
	assign p25 = 27'(yabs_s6) * cjd_pkg::DIV25_RECIP;

	always_ff @(posedge clk) begin
		if (adv[6]) begin
			mode_s7 <= mode_s6;
			jn_s7   <= jn_s6;
			dy_s7   <= dy_s6;
			mo_s7   <= mo_s6;
			yr_s7   <= yr_s6;
			yabs_s7 <= yabs_s6;
			nmon_s7 <= nmon_s6;
			q25_s7  <= p25[cjd_pkg::DIV25_SHIFT +: 9];
		end
	end

	// Stage 8 logic: Gregorian leap rule, day of year and the mode select.
	always_comb begin
		div25 = (14'(q25_s7) * cjd_pkg::CENTURY_FACTOR) == {1'b0, yabs_s7};
		// A century year is a leap year only when it divides by 400.
		leap  = div25 ? (yabs_s7[3:0] == 4'd0) : (yabs_s7[1:0] == 2'd0);
		doy   = {{4{dy_s7[5]}}, dy_s7} + {1'b0, cjd_pkg::days_before(nmon_s7)} +
		        {9'b0, leap && (nmon_s7 >= 4'd2)};
		rsp_d = '0;
		unique case (cjd_pkg::mode_t'(mode_s7))
			cjd_pkg::MODE_TO_DAY_NUMBER: begin
				rsp_d.day_number_out = jn_s7;
			end
			cjd_pkg::MODE_TO_DATE: begin
				rsp_d.year_out        = yr_s7[11:0];
				rsp_d.month_out       = mo_s7[3:0];
				rsp_d.day_out         = dy_s7[4:0];
				rsp_d.day_of_year_out = doy[8:0];
			end
			default: begin
				rsp_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv[7]) begin
			rsp_s8 <= rsp_d;
		end
	end

endmodule

// ===== rtl/core/cjd_checker.sv =====
// Port-level checks for the converter and the bind that attaches them to it.
// Depends on cjd_pkg and on the ports of calendar_julian_day_converter.

module cjd_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               req_ready,
	input logic               rsp_valid,
	input logic               rsp_ready,
	input cjd_pkg::rsp_word_t rsp_data
);

	// A stalled result word stays put.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("result word changed while stalled");

	// With the result register empty the pipeline has room for a word.
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid |-> req_ready)
		else $error("request stalled with an empty result register");

	// When the receiver takes a word every stage moves, so a request is taken too.
	a_drain_ready: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_ready |-> req_ready)
		else $error("request stalled while the receiver was ready");

	// A day number result never carries date fields.
	a_mode_fields: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_data.day_number_out != 22'd0) |->
			(rsp_data.year_out == 12'd0) && (rsp_data.month_out == 4'd0) &&
			(rsp_data.day_out == 5'd0) && (rsp_data.day_of_year_out == 9'd0))
		else $error("date fields set in a day number result");

endmodule

bind calendar_julian_day_converter cjd_checker u_cjd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_ready (request.ready),
	.rsp_valid (result.valid),
	.rsp_ready (result.ready),
	.rsp_data  (result.data)
);
